@@ rtl/pointer_report_generator_top_macros.svh @@
// Assertion macros shared by the pointer report generator
`ifndef POINTER_REPORT_GENERATOR_TOP_MACROS_SVH
`define POINTER_REPORT_GENERATOR_TOP_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle
`define PRG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that an antecedent implies a consequent in the next cycle
`define PRG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/prg_pkg.sv @@
// Package: types, constants and helpers for the pointer report generator
package prg_pkg;
    localparam logic [1:0] MODE_ABS = 2'd0;
    localparam logic [1:0] MODE_REL = 2'd1;
    localparam logic [1:0] MODE_DIGI = 2'd2;
    localparam logic [1:0] KIND_REL_ALL = 2'd3;
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_OX = 3'd1;
    localparam logic [2:0] REG_OY = 3'd2;
    localparam logic [2:0] REG_DW = 3'd3;
    localparam logic [2:0] REG_DH = 3'd4;
    localparam logic [2:0] REG_SW = 3'd5;
    localparam logic [2:0] REG_SH = 3'd6;
    localparam logic [2:0] REG_GAIN = 3'd7;
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_PRESS = 2'd1;
    localparam logic [1:0] EDGE_RELEASE = 2'd2;
    localparam int QW = 17;
    localparam int NW = 49;
    localparam int DW = 26;
    localparam int QCW = 5;

    typedef enum logic [3:0] {
        t_ST_IDLE, t_ST_PREP_X, t_ST_DIV_X, t_ST_PREP_Y, t_ST_DIV_Y,
        t_ST_REL_SQ, t_ST_REL_MUL, t_ST_REL_GX, t_ST_REL_GY, t_ST_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic [QW-1:0] quot;
    } t_div_rsp;

    function automatic logic [1:0] edge_code(input logic now, input logic was);
        logic [1:0] r;
        r = EDGE_NONE;
        if (now && !was) r = EDGE_PRESS;
        else if (!now && was) r = EDGE_RELEASE;
        return r;
    endfunction
endpackage

@@ rtl/prg_divider.sv @@
// Restoring divider, one quotient bit per cycle, 17 quotient bits
module prg_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prg_pkg::t_div_req i_req,
    output prg_pkg::t_div_rsp o_rsp
);
    logic [prg_pkg::NW-1:0] r_rem, n_rem;
    logic [prg_pkg::DW-1:0] r_den;
    logic [prg_pkg::QW-1:0] r_quot, n_quot;
    logic [prg_pkg::QCW-1:0] r_cnt;
    logic r_busy, r_done;
    logic [prg_pkg::NW:0] trial;

    // trial subtract of den shifted to the current bit
    always_comb begin
        trial = {1'b0, r_rem} - ({{(prg_pkg::NW+1-prg_pkg::DW){1'b0}}, r_den}
                << r_cnt);
        n_rem = r_rem;
        n_quot = r_quot << 1;
        if (!trial[prg_pkg::NW]) begin
            n_rem = trial[prg_pkg::NW-1:0];
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt <= prg_pkg::QCW'(prg_pkg::QW - 1);
                r_rem <= i_req.num;
                r_den <= i_req.den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quot <= n_quot;
                r_cnt <= r_cnt - prg_pkg::QCW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

@@ rtl/pointer_report_generator_top.sv @@
// Top level of the pointer report generator
//
//  channel | direction | handshake              | content
//  input   | in        | i_valid / o_stall      | operation, buttons, position, pressure
//  output  | out       | o_valid / i_stall      | one report word per input word
//  config  | in        | i_cfg_we, i_cfg_index  | eight registers, write only
//
// An absolute or digitizer word goes per axis through a set-up state and
// then the shared restoring divider (17 quotient bits, one a cycle, then
// the done strobe), then through one load state and the idle state. An axis
// that clamps skips its division. A relative word goes through one shared
// 34x34 multiplier: two squares for the jump test, two gain products, then
// load and idle. A release word goes straight to the load state. Reset is
// synchronous and clears control and tracking state; datapath registers
// are left as they are. The next word is taken once the finished report is
// loaded in the output register; a stall on the output holds that report
// unchanged and holds the load.
`include "pointer_report_generator_top_macros.svh"
module pointer_report_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_button_bits,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic [15:0] i_pen_pressure,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_report_kind,
    output logic signed [16:0] o_out_x,
    output logic signed [16:0] o_out_y,
    output logic [10:0] o_out_pressure,
    output logic [7:0]  o_out_buttons,
    output logic [1:0]  o_left_edge,
    output logic [1:0]  o_right_edge,
    output logic [1:0]  o_middle_edge
);
    // configuration registers
    logic [1:0] r_mode;
    logic signed [15:0] r_org_x, r_org_y;
    logic [15:0] r_dw, r_dh, r_sw, r_sh, r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= prg_pkg::MODE_ABS;
            r_org_x <= '0;
            r_org_y <= '0;
            r_dw <= 16'd1920;
            r_dh <= 16'd1080;
            r_sw <= 16'd1920;
            r_sh <= 16'd1080;
            r_gain <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                prg_pkg::REG_MODE: r_mode <= i_cfg_data[1:0];
                prg_pkg::REG_OX:   r_org_x <= i_cfg_data;
                prg_pkg::REG_OY:   r_org_y <= i_cfg_data;
                prg_pkg::REG_DW:   r_dw <= i_cfg_data;
                prg_pkg::REG_DH:   r_dh <= i_cfg_data;
                prg_pkg::REG_SW:   r_sw <= i_cfg_data;
                prg_pkg::REG_SH:   r_sh <= i_cfg_data;
                prg_pkg::REG_GAIN: r_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and latched input word
    prg_pkg::t_state r_state, n_state;
    logic r_op;
    logic [7:0] r_btn;
    logic signed [31:0] r_px, r_py;
    logic [15:0] r_pr;
    logic [1:0] r_wmode;

    // block state
    logic [2:0] r_prev_btn;
    logic r_first;
    logic signed [31:0] r_prev_x, r_prev_y;
    logic signed [17:0] r_carry_x, r_carry_y;
    logic [14:0] r_digi_x, r_digi_y;

    // results under construction
    logic signed [16:0] r_res_x, r_res_y;

    // output register
    logic r_ovalid;
    logic [1:0] r_kind, r_el, r_er, r_em;
    logic signed [16:0] r_ox, r_oy;
    logic [10:0] r_opr;
    logic [7:0] r_obt;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != prg_pkg::t_ST_IDLE);

    prg_pkg::t_div_req div_req;
    prg_pkg::t_div_rsp div_rsp;
    prg_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    // shared multiplier: signed 34 x signed 34 operands, used for the
    // jump test squares and the gain products
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [67:0] r_prod;
    assign mul_p = mul_a * mul_b;

    // mapping set-up for the axis in flight
    logic is_y, is_digi;
    logic signed [33:0] pos_s, org_s, n_val;
    logic [15:0] size_raw;
    logic [23:0] d_val;
    logic clamp_lo, clamp_hi;
    logic [16:0] clamp_val;
    logic [16:0] max_val;

    always_comb begin
        is_y = (r_state == prg_pkg::t_ST_PREP_Y);
        is_digi = (r_wmode == prg_pkg::MODE_DIGI);
        pos_s = is_y ? 34'(r_py) : 34'(r_px);
        org_s = is_digi ? 34'sd0 : (is_y ? 34'(r_org_y) <<< 8 : 34'(r_org_x) <<< 8);
        size_raw = is_digi ? (is_y ? r_sh : r_sw) : (is_y ? r_dh : r_dw);
        if (size_raw == 16'd0) size_raw = 16'd1;
        d_val = {size_raw, 8'd0};
        n_val = pos_s - org_s;
        max_val = is_digi ? 17'd32767 : 17'd65535;
        clamp_lo = (n_val <= 34'sd0);
        clamp_hi = (n_val >= $signed({10'd0, d_val}));
        clamp_val = clamp_lo ? 17'd0 : max_val;
        div_req.start = (r_state == prg_pkg::t_ST_PREP_X || r_state == prg_pkg::t_ST_PREP_Y)
                        && !clamp_lo && !clamp_hi;
        // absolute: n*65535 / d ; digitizer: (2n*32767 + d) / 2d
        if (is_digi) begin
            div_req.num = prg_pkg::NW'(n_val[24:0]) * prg_pkg::NW'(65534)
                          + prg_pkg::NW'(d_val);
            div_req.den = {1'b0, d_val, 1'b0};
        end else begin
            div_req.num = prg_pkg::NW'(n_val[24:0]) * prg_pkg::NW'(65535);
            div_req.den = {2'b0, d_val};
        end
    end

    // relative path
    logic signed [32:0] dx, dy;
    logic r_jump;
    logic signed [33:0] accx, accy;
    logic signed [16:0] mvx, mvy;
    logic signed [33:0] r_acc_x, r_acc_y;
    logic signed [67:0] sq_lim;
    assign dx = 33'(r_px) - 33'(r_prev_x);
    assign dy = 33'(r_py) - 33'(r_prev_y);
    assign sq_lim = 68'sd10485760000;

    // squares first, then the gain products; a jump zeroes the delta
    always_comb begin
        mul_a = 34'(dx);
        mul_b = 34'(dx);
        unique case (r_state)
            prg_pkg::t_ST_REL_MUL: begin
                mul_a = 34'(dy);
                mul_b = 34'(dy);
            end
            prg_pkg::t_ST_REL_GX: begin
                mul_a = r_jump ? 34'sd0 : 34'(dx);
                mul_b = $signed({18'd0, r_gain});
            end
            prg_pkg::t_ST_REL_GY: begin
                mul_a = r_jump ? 34'sd0 : 34'(dy);
                mul_b = $signed({18'd0, r_gain});
            end
            default: ;
        endcase
    end

    function automatic logic signed [16:0] clamp_mv(input logic signed [33:0] mv);
        logic signed [16:0] r;
        if (mv > 34'sd500) r = 17'sd500;
        else if (mv < -34'sd500) r = -17'sd500;
        else r = mv[16:0];
        return r;
    endfunction

    logic signed [33:0] mvx_w, mvy_w;
    always_comb begin
        accx = r_acc_x;
        accy = r_acc_y;
        // truncation toward zero of acc / 65536
        mvx_w = (accx < 34'sd0) ? -((-accx) >>> 16) : (accx >>> 16);
        mvy_w = (accy < 34'sd0) ? -((-accy) >>> 16) : (accy >>> 16);
        mvx = clamp_mv(mvx_w);
        mvy = clamp_mv(mvy_w);
    end

    // digitizer pressure, saturated at full scale
    logic [27:0] pr_scaled;
    assign pr_scaled = (28'(r_pr) * 28'd2047) >> 15;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prg_pkg::t_ST_IDLE:
                if (in_acc) begin
                    if (i_operation) n_state = prg_pkg::t_ST_DONE;
                    else if (r_mode == prg_pkg::MODE_REL) n_state = prg_pkg::t_ST_REL_SQ;
                    else n_state = prg_pkg::t_ST_PREP_X;
                end
            prg_pkg::t_ST_PREP_X: n_state = div_req.start ? prg_pkg::t_ST_DIV_X
                                                           : prg_pkg::t_ST_PREP_Y;
            prg_pkg::t_ST_DIV_X:  if (div_rsp.done) n_state = prg_pkg::t_ST_PREP_Y;
            prg_pkg::t_ST_PREP_Y: n_state = div_req.start ? prg_pkg::t_ST_DIV_Y
                                                           : prg_pkg::t_ST_DONE;
            prg_pkg::t_ST_DIV_Y:  if (div_rsp.done) n_state = prg_pkg::t_ST_DONE;
            prg_pkg::t_ST_REL_SQ: n_state = prg_pkg::t_ST_REL_MUL;
            prg_pkg::t_ST_REL_MUL: n_state = prg_pkg::t_ST_REL_GX;
            prg_pkg::t_ST_REL_GX: n_state = prg_pkg::t_ST_REL_GY;
            prg_pkg::t_ST_REL_GY: n_state = prg_pkg::t_ST_DONE;
            prg_pkg::t_ST_DONE:   if (!r_ovalid || !i_stall) n_state = prg_pkg::t_ST_IDLE;
            default: n_state = prg_pkg::t_ST_IDLE;
        endcase
    end

    logic load_out;
    assign load_out = (r_state == prg_pkg::t_ST_DONE) && (!r_ovalid || !i_stall);

    // datapath and state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prg_pkg::t_ST_IDLE;
            r_ovalid <= 1'b0;
            r_prev_btn <= '0;
            r_first <= 1'b1;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_carry_x <= '0;
            r_carry_y <= '0;
            r_digi_x <= '0;
            r_digi_y <= '0;
        end else begin
            r_state <= n_state;
            if (load_out) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (in_acc) begin
                r_op <= i_operation;
                r_btn <= i_button_bits;
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_pr <= i_pen_pressure;
                r_wmode <= r_mode;
            end
            unique case (r_state)
                prg_pkg::t_ST_PREP_X: if (!div_req.start) r_res_x <= clamp_val;
                prg_pkg::t_ST_DIV_X:  if (div_rsp.done) r_res_x <= div_rsp.quot;
                prg_pkg::t_ST_PREP_Y: if (!div_req.start) r_res_y <= clamp_val;
                prg_pkg::t_ST_DIV_Y:  if (div_rsp.done) r_res_y <= div_rsp.quot;
                prg_pkg::t_ST_REL_SQ: begin
                    // hold dx squared, test axis limits
                    r_prod <= mul_p;
                    r_jump <= r_first || dx > 33'sd102400 || dx < -33'sd102400
                              || dy > 33'sd102400 || dy < -33'sd102400;
                end
                prg_pkg::t_ST_REL_MUL: begin
                    if (!r_jump && (r_prod + mul_p > sq_lim)) r_jump <= 1'b1;
                end
                // accumulate onto the carry, which a jump drops
                prg_pkg::t_ST_REL_GX:
                    r_acc_x <= (r_jump ? 34'sd0 : 34'(r_carry_x)) + $signed(mul_p[33:0]);
                prg_pkg::t_ST_REL_GY:
                    r_acc_y <= (r_jump ? 34'sd0 : 34'(r_carry_y)) + $signed(mul_p[33:0]);
                default: ;
            endcase
            if (load_out) begin
                r_opr <= '0;
                r_obt <= '0;
                r_el <= prg_pkg::EDGE_NONE;
                r_er <= prg_pkg::EDGE_NONE;
                r_em <= prg_pkg::EDGE_NONE;
                r_ox <= '0;
                r_oy <= '0;
                if (r_op) begin
                    r_kind <= prg_pkg::KIND_REL_ALL;
                    if (r_wmode == prg_pkg::MODE_DIGI) begin
                        r_ox <= {2'b0, r_digi_x};
                        r_oy <= {2'b0, r_digi_y};
                    end else begin
                        r_el <= prg_pkg::EDGE_RELEASE;
                        r_er <= prg_pkg::EDGE_RELEASE;
                        r_em <= prg_pkg::EDGE_RELEASE;
                        r_prev_btn <= '0;
                        if (r_wmode == prg_pkg::MODE_REL) begin
                            r_first <= 1'b1;
                            r_carry_x <= '0;
                            r_carry_y <= '0;
                        end
                    end
                end else if (r_wmode == prg_pkg::MODE_DIGI) begin
                    r_kind <= prg_pkg::MODE_DIGI;
                    r_digi_x <= r_res_x[14:0];
                    r_digi_y <= r_res_y[14:0];
                    r_ox <= r_res_x;
                    r_oy <= r_res_y;
                    r_opr <= (pr_scaled > 28'd2047) ? 11'd2047 : pr_scaled[10:0];
                    r_obt <= r_btn | 8'h20;
                end else begin
                    if (r_wmode == prg_pkg::MODE_REL) begin
                        r_kind <= prg_pkg::MODE_REL;
                        r_ox <= mvx;
                        r_oy <= mvy;
                        r_carry_x <= 18'(accx - (mvx_w <<< 16));
                        r_carry_y <= 18'(accy - (mvy_w <<< 16));
                        r_first <= 1'b0;
                        r_prev_x <= r_px;
                        r_prev_y <= r_py;
                    end else begin
                        r_kind <= prg_pkg::MODE_ABS;
                        r_ox <= r_res_x;
                        r_oy <= r_res_y;
                    end
                    r_el <= prg_pkg::edge_code(r_btn[0], r_prev_btn[0]);
                    r_er <= prg_pkg::edge_code(r_btn[1], r_prev_btn[1]);
                    r_em <= prg_pkg::edge_code(r_btn[2], r_prev_btn[2]);
                    r_prev_btn <= r_btn[2:0];
                end
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_report_kind = r_kind;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_pressure = r_opr;
    assign o_out_buttons = r_obt;
    assign o_left_edge = r_el;
    assign o_right_edge = r_er;
    assign o_middle_edge = r_em;

    `PRG_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_state != prg_pkg::t_ST_IDLE, o_stall)
    `PRG_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, load_out, o_valid)
    `PRG_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, div_req.start, !div_rsp.busy)
endmodule
